// ===== src/pef_pkg.sv =====
`default_nettype none

package pef_pkg;

   localparam logic [7:0] HDR_BYTE = 8'h7B;
   localparam logic [7:0] TRL_BYTE = 8'h7D;
   localparam logic [7:0] ESC_BYTE = 8'h1B;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       hdr;
      logic       esc;
      logic       prev_valid;
      logic [7:0] prev_byte;
      logic       emit_data;
      logic [7:0] data;
      logic       trl;
   } desc_type;

endpackage

`default_nettype wire

// ===== src/pef_front.sv =====
`default_nettype none

module pef_front
   import pef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   input  wire logic       q_full,
   output logic            push_valid,
   output desc_type        push_desc
);

   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       in_frame_ff, in_frame_in;
   logic       accept;
   logic       match;
   logic       special;
   logic       hold;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      match   = held_valid_ff && (held_byte_ff == req_data_byte);
      special = (req_data_byte == HDR_BYTE) || (req_data_byte == TRL_BYTE);
      hold    = !match && special;

      push_desc.hdr        = !in_frame_ff;
      push_desc.esc        = match;
      push_desc.prev_valid = held_valid_ff && !match;
      push_desc.prev_byte  = held_byte_ff;
      push_desc.emit_data  = (!match && !special) || (hold && req_last_byte);
      push_desc.data       = req_data_byte;
      push_desc.trl        = req_last_byte;

      push_valid = accept && (push_desc.hdr || push_desc.esc || push_desc.prev_valid ||
                              push_desc.emit_data || push_desc.trl);

      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      in_frame_in   = in_frame_ff;
      if (accept) begin
         held_valid_in = hold && !req_last_byte;
         in_frame_in   = !req_last_byte;
         if (hold) begin
            held_byte_in = req_data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'h00;
         in_frame_ff   <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         in_frame_ff   <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pef_queue.sv =====
`default_nettype none

module pef_queue
   import pef_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire desc_type push_desc,
   output logic          full,
   output logic          head_valid,
   output desc_type      head_desc,
   input  wire logic     pop
);

   desc_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ===== src/pef_back.sv =====
`default_nettype none

module pef_back
   import pef_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire desc_type    head_desc,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_run,
   output logic             rsp_frame_end
);

   logic [7:0] seq [8];
   logic [3:0] seq_len;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       end_of_run_ff;
   logic       frame_end_ff;
   logic       load;
   logic       at_end;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         seq[k] = TRL_BYTE;
      end
      seq_len = 4'd0;
      if (head_desc.hdr) begin
         seq[0]  = HDR_BYTE;
         seq[1]  = HDR_BYTE;
         seq_len = 4'd2;
      end
      if (head_desc.esc) begin
         seq[seq_len[2:0]]        = ESC_BYTE;
         seq[seq_len[2:0] + 3'd1] = ESC_BYTE;
         seq[seq_len[2:0] + 3'd2] = head_desc.data;
         seq[seq_len[2:0] + 3'd3] = head_desc.data;
         seq_len                  = seq_len + 4'd4;
      end
      if (head_desc.prev_valid) begin
         seq[seq_len[2:0]] = head_desc.prev_byte;
         seq_len           = seq_len + 4'd1;
      end
      if (head_desc.emit_data) begin
         seq[seq_len[2:0]] = head_desc.data;
         seq_len           = seq_len + 4'd1;
      end
      if (head_desc.trl) begin
         seq_len = seq_len + 4'd2;
      end
   end

   assign load   = head_valid && (!rsp_valid_ff || rsp_ready);
   assign at_end = ({1'b0, idx_ff} == seq_len - 4'd1);
   assign pop    = load && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = at_end ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= seq[idx_ff];
         end_of_run_ff <= at_end;
         frame_end_ff  <= at_end && head_desc.trl;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_end_of_run = end_of_run_ff;
   assign rsp_frame_end  = frame_end_ff;

endmodule

`default_nettype wire

// ===== src/pair_escape_frame_encoder.sv =====
// Channel  Direction  Handshake              Payload
// req_     in         req_valid/req_ready    req_data_byte[7:0], req_last_byte
// rsp_     out        rsp_valid/rsp_ready    rsp_out_byte[7:0], rsp_end_of_run, rsp_frame_end
//
// The front takes one transaction per cycle while its two-entry queue has room.
// The back sends one byte per cycle from the queue head while rsp_ready is high;
// a transaction yields zero to six bytes. Synchronous reset clears the held byte,
// the frame state, the queue and the output valid flag. rsp_ready low holds the
// output byte; the front keeps taking transactions until the queue fills.
`default_nettype none

module pair_escape_frame_encoder
   import pef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_end_of_run,
   output logic            rsp_frame_end
);

   logic     q_full;
   logic     push_valid;
   desc_type push_desc;
   logic     head_valid;
   desc_type head_desc;
   logic     pop;

   pef_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_desc     (push_desc)
   );

   pef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .full       (q_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop)
   );

   pef_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_desc      (head_desc),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== src/pef_checker.sv =====
`default_nettype none

module pef_checker
   import pef_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_end_of_run,
   input wire logic       rsp_frame_end
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_end_of_run) && $stable(rsp_frame_end))
      else $error("stalled response changed");

   a_frame_end_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_end_of_run && rsp_out_byte == TRL_BYTE)
      else $error("frame end not on final trailer byte");

   a_trailer_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_end |-> $past(rsp_out_byte) == TRL_BYTE)
      else $error("frame end not preceded by trailer byte");

endmodule

bind pair_escape_frame_encoder pef_checker u_pef_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
   import pef_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int          RANDOM_ITEMS  = 250;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       frame_end;
   } enc_byte_type;

   class framed_stream_book_type;
      enc_byte_type expected_bytes[$];
      bit           held_valid;
      logic [7:0]   held_byte;
      bit           in_frame;
      int           failures;

      function new();
         held_valid = 1'b0;
         held_byte  = 8'h00;
         in_frame   = 1'b0;
         failures   = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic fend);
         enc_byte_type e;
         e.out_byte   = b;
         e.end_of_run = 1'b0;
         e.frame_end  = fend;
         expected_bytes.push_back(e);
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // Work out the encoded bytes for one accepted payload transaction.
      function void predict_frame_bytes(logic [7:0] b, logic last);
         enc_byte_type tail;
         if (!in_frame) begin
            push_byte(HDR_BYTE, 1'b0);
            push_byte(HDR_BYTE, 1'b0);
            in_frame = 1'b1;
         end
         if (held_valid && held_byte == b) begin
            push_byte(ESC_BYTE, 1'b0);
            push_byte(ESC_BYTE, 1'b0);
            push_byte(b, 1'b0);
            push_byte(b, 1'b0);
            held_valid = 1'b0;
         end else begin
            if (held_valid) begin
               push_byte(held_byte, 1'b0);
               held_valid = 1'b0;
            end
            if (b == HDR_BYTE || b == TRL_BYTE) begin
               held_byte  = b;
               held_valid = 1'b1;
            end else begin
               push_byte(b, 1'b0);
            end
         end
         if (last) begin
            if (held_valid) begin
               push_byte(held_byte, 1'b0);
               held_valid = 1'b0;
            end
            push_byte(TRL_BYTE, 1'b0);
            push_byte(TRL_BYTE, 1'b1);
            in_frame = 1'b0;
         end
         // flag the final expected byte (from this transaction if it produced any)
         tail = expected_bytes.pop_back();
         tail.end_of_run = 1'b1;
         expected_bytes.push_back(tail);
      endfunction

      function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
         failures++;
         $display("%0t: mismatch on %s: expected %h, actual %h", $time, what, exp_v, act_v);
      endfunction

      function void check_out_byte(logic [7:0] b, logic eor, logic fend);
         enc_byte_type e;
         if (expected_bytes.size() == 0) begin
            failures++;
            $display("%0t: unexpected output byte: expected none, actual %h %b %b",
                     $time, b, eor, fend);
            return;
         end
         e = expected_bytes.pop_front();
         if (b !== e.out_byte)     report("out_byte", e.out_byte, b);
         if (eor !== e.end_of_run) report("end_of_run", {7'b0, e.end_of_run}, {7'b0, eor});
         if (fend !== e.frame_end) report("frame_end", {7'b0, e.frame_end}, {7'b0, fend});
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_of_run;
   logic       rsp_frame_end;

   bit                     calm = 1'b0;
   int unsigned            cycles = 0;
   framed_stream_book_type book = new();

   pair_escape_frame_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_frame_end  (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 17);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            book.predict_frame_bytes(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready)
            book.check_out_byte(rsp_out_byte, rsp_end_of_run, rsp_frame_end);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_payload(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_output();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   function automatic logic [7:0] pick_payload();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)  return HDR_BYTE;
      if (r < 7)  return TRL_BYTE;
      if (r == 7) return ESC_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int sent;
      int len;
      bit drained;
      sent    = 0;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-byte frames at the extremes
      send_payload(8'h00, 1'b1);
      send_payload(8'hFF, 1'b1);
      send_payload(HDR_BYTE, 1'b1);
      send_payload(TRL_BYTE, 1'b1);
      // odd run: third byte goes out unchanged
      send_payload(HDR_BYTE, 1'b0);
      send_payload(HDR_BYTE, 1'b0);
      send_payload(HDR_BYTE, 1'b1);
      // even run of four
      send_payload(TRL_BYTE, 1'b0);
      send_payload(TRL_BYTE, 1'b0);
      send_payload(TRL_BYTE, 1'b0);
      send_payload(TRL_BYTE, 1'b1);
      // alternating specials never pair
      send_payload(HDR_BYTE, 1'b0);
      send_payload(TRL_BYTE, 1'b0);
      send_payload(HDR_BYTE, 1'b0);
      send_payload(ESC_BYTE, 1'b1);
      // held byte must not pair across a frame boundary
      send_payload(HDR_BYTE, 1'b1);
      send_payload(HDR_BYTE, 1'b1);
      send_payload(TRL_BYTE, 1'b0);
      send_payload(TRL_BYTE, 1'b1);
      send_payload(8'h55, 1'b0);
      send_payload(8'hAA, 1'b1);

      drain_output();

      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            send_payload(pick_payload(), i == len - 1);
            sent++;
            calm = (sent >= 90 && sent < 150);
         end
         if (!drained && sent >= 170) begin
            drained = 1'b1;
            drain_output();
         end
      end

      drain_output();
      repeat (20) @(posedge clock);
      if (book.failures == 0 && book.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
